[src/vigenere_decrypt_alnum_macros.svh]
// Assertion macros shared by the vigenere_decrypt_alnum RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef VIGENERE_DECRYPT_ALNUM_MACROS_SVH
`define VIGENERE_DECRYPT_ALNUM_MACROS_SVH

// property that holds on every enabled edge
`define VDA_ASSERT_HOLD(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("vda: invariant violated");

// same-cycle implication
`define VDA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vda: implication violated");

// next-cycle implication
`define VDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vda: next-cycle implication violated");

`endif

[src/vda_pkg.sv]
// Package for vigenere_decrypt_alnum: widths, character codes, item struct
// and constant-divisor reductions. Depends on nothing.
package vda_pkg;

   localparam int KEY_MAX     = 8;
   localparam int TEXT_W      = 8;
   localparam int KEY_BYTES_W = 64;
   localparam int KEY_LEN_W   = 4;
   localparam int POS_W       = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int DIGIT_W     = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BYTES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 2'd1;

   localparam logic [TEXT_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [TEXT_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [TEXT_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [TEXT_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [TEXT_W-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [TEXT_W-1:0] CH_DIGIT_9 = 8'h39;

   localparam logic [DIGIT_W-1:0] SPAN_ALPHA = 5'd26;
   localparam logic [DIGIT_W-1:0] SPAN_DIGIT = 5'd10;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_LOWER = 2'd1,
      KIND_UPPER = 2'd2,
      KIND_DIGIT = 2'd3
   } vda_kind_type;

   typedef struct packed {
      logic                 last;
      vda_kind_type         kind;
      logic [TEXT_W-1:0]    text;
      logic [DIGIT_W-1:0]   offset;
      logic [DIGIT_W-1:0]   shift;
   } vda_item_type;

   // x mod 26 by reciprocal 79/2048 with one correction step
   function automatic logic [DIGIT_W-1:0] mod26(input logic [TEXT_W-1:0] x);
      logic [15:0] prod;
      logic [8:0]  q;
      logic [8:0]  r;
      prod = {8'd0, x} * 16'd79;
      q    = {4'd0, prod[15:11]};
      r    = {1'b0, x} - 9'(q * 9'd26);
      if (r >= 9'd26) begin
         r = r - 9'd26;
      end
      return r[DIGIT_W-1:0];
   endfunction

   // x mod 10 by reciprocal 205/2048 with one correction step
   function automatic logic [DIGIT_W-1:0] mod10(input logic [TEXT_W-1:0] x);
      logic [15:0] prod;
      logic [8:0]  q;
      logic [8:0]  r;
      prod = {8'd0, x} * 16'd205;
      q    = {4'd0, prod[15:11]};
      r    = {1'b0, x} - 9'(q * 9'd10);
      if (r >= 9'd10) begin
         r = r - 9'd10;
      end
      return r[DIGIT_W-1:0];
   endfunction

endpackage

[src/vda_front.sv]
// Front end: key registers, key position, byte classification and shift
// reduction. Uses vda_pkg and the shared assertion macros.
`include "vigenere_decrypt_alnum_macros.svh"

module vda_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [vda_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vda_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [vda_pkg::TEXT_W-1:0]         req_tdata,  // text_byte
   input  logic                               req_tlast,  // last_in
   output logic                               push_valid,
   input  logic                               push_ready,
   output vda_pkg::vda_item_type              push_item
);

   logic [vda_pkg::KEY_BYTES_W-1:0] key_bytes_ff, key_bytes_in;
   logic [vda_pkg::KEY_LEN_W-1:0]   key_len_ff, key_len_in;
   logic [vda_pkg::POS_W-1:0]       key_pos_ff, key_pos_in;

   logic [vda_pkg::KEY_LEN_W-1:0]   eff_len;
   logic [vda_pkg::POS_W-1:0]       pos_cur;
   logic [vda_pkg::KEY_LEN_W-1:0]   pos_next;
   logic [vda_pkg::TEXT_W-1:0]      key_byte;
   logic [vda_pkg::TEXT_W-1:0]      shift_raw;
   logic                            accept;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   always_comb begin
      key_bytes_in = key_bytes_ff;
      key_len_in   = key_len_ff;
      if (csr_we) begin
         unique case (csr_index)
            vda_pkg::CSR_KEY_BYTES:  key_bytes_in = csr_wdata;
            vda_pkg::CSR_KEY_LENGTH: key_len_in   = csr_wdata[vda_pkg::KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_len = key_len_ff;
      if (key_len_ff == '0) begin
         eff_len = vda_pkg::KEY_LEN_W'(1);
      end else if (key_len_ff > vda_pkg::KEY_LEN_W'(vda_pkg::KEY_MAX)) begin
         eff_len = vda_pkg::KEY_LEN_W'(vda_pkg::KEY_MAX);
      end
   end

   always_comb begin
      pos_cur = key_pos_ff;
      if ({1'b0, key_pos_ff} >= eff_len) begin
         pos_cur = '0;
      end
      pos_next   = {1'b0, pos_cur} + vda_pkg::KEY_LEN_W'(1);
      key_pos_in = key_pos_ff;
      if (accept) begin
         if (req_tlast || pos_next >= eff_len) begin
            key_pos_in = '0;
         end else begin
            key_pos_in = pos_next[vda_pkg::POS_W-1:0];
         end
      end
   end

   assign key_byte  = key_bytes_ff[{pos_cur, 3'b000} +: vda_pkg::TEXT_W];
   assign shift_raw = (key_byte >= vda_pkg::CH_UPPER_A) ? key_byte - vda_pkg::CH_UPPER_A : '0;

   always_comb begin
      push_item.last   = req_tlast;
      push_item.text   = req_tdata;
      push_item.kind   = vda_pkg::KIND_OTHER;
      push_item.offset = '0;
      push_item.shift  = '0;
      if (req_tdata >= vda_pkg::CH_LOWER_A && req_tdata <= vda_pkg::CH_LOWER_Z) begin
         push_item.kind   = vda_pkg::KIND_LOWER;
         push_item.offset = vda_pkg::DIGIT_W'(req_tdata - vda_pkg::CH_LOWER_A);
         push_item.shift  = vda_pkg::mod26(shift_raw);
      end else if (req_tdata >= vda_pkg::CH_DIGIT_0 && req_tdata <= vda_pkg::CH_DIGIT_9) begin
         push_item.kind   = vda_pkg::KIND_DIGIT;
         push_item.offset = vda_pkg::DIGIT_W'(req_tdata - vda_pkg::CH_DIGIT_0);
         push_item.shift  = vda_pkg::mod10(shift_raw);
      end else if (req_tdata >= vda_pkg::CH_UPPER_A && req_tdata <= vda_pkg::CH_UPPER_Z) begin
         push_item.kind   = vda_pkg::KIND_UPPER;
         push_item.offset = vda_pkg::DIGIT_W'(req_tdata - vda_pkg::CH_UPPER_A);
         push_item.shift  = vda_pkg::mod26(shift_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff <= '0;
         key_len_ff   <= vda_pkg::KEY_LEN_W'(1);
         key_pos_ff   <= '0;
      end else begin
         key_bytes_ff <= key_bytes_in;
         key_len_ff   <= key_len_in;
         key_pos_ff   <= key_pos_in;
      end
   end

   `VDA_ASSERT_IMPL(a_digit_range, clock, reset,
      push_valid && push_item.kind == vda_pkg::KIND_DIGIT,
      push_item.shift < vda_pkg::SPAN_DIGIT && push_item.offset < vda_pkg::SPAN_DIGIT)
   `VDA_ASSERT_IMPL(a_alpha_range, clock, reset,
      push_valid && (push_item.kind == vda_pkg::KIND_LOWER ||
                     push_item.kind == vda_pkg::KIND_UPPER),
      push_item.shift < vda_pkg::SPAN_ALPHA && push_item.offset < vda_pkg::SPAN_ALPHA)

endmodule

[src/vda_queue.sv]
// Short queue between front and back ends, holding classified requests.
// Uses vda_pkg and the shared assertion macros.
`include "vigenere_decrypt_alnum_macros.svh"

module vda_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  vda_pkg::vda_item_type  push_item,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output vda_pkg::vda_item_type  pop_item
);

   vda_pkg::vda_item_type           slot_ff [vda_pkg::QUEUE_DEPTH];
   logic [vda_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [vda_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [vda_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                            push, pop;

   assign push_ready = count_ff != vda_pkg::QCNT_W'(vda_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + vda_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + vda_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + vda_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - vda_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `VDA_ASSERT_HOLD(a_count_bound, clock, reset,
      count_ff <= vda_pkg::QCNT_W'(vda_pkg::QUEUE_DEPTH))
   `VDA_ASSERT_IMPL(a_ptr_gap, clock, reset,
      count_ff == '0, wr_ptr_ff == rd_ptr_ff)

endmodule

[src/vda_back.sv]
// Back end: modular subtraction within each alphabet and the response
// register. Uses vda_pkg and the shared assertion macros.
`include "vigenere_decrypt_alnum_macros.svh"

module vda_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  vda_pkg::vda_item_type       pop_item,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [vda_pkg::TEXT_W-1:0]  rsp_tdata,  // plain_byte
   output logic                        rsp_tlast   // last_out
);

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [vda_pkg::TEXT_W-1:0]    rsp_data_ff;
   logic                          rsp_last_ff;
   logic [vda_pkg::TEXT_W-1:0]    plain;
   logic [vda_pkg::TEXT_W-1:0]    base;
   logic [vda_pkg::DIGIT_W-1:0]   span;
   logic [vda_pkg::DIGIT_W:0]     diff;
   logic                          pop;

   assign pop_ready = !rsp_valid_ff || rsp_tready;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      base = vda_pkg::CH_UPPER_A;
      span = vda_pkg::SPAN_ALPHA;
      unique case (pop_item.kind)
         vda_pkg::KIND_LOWER: base = vda_pkg::CH_LOWER_A;
         vda_pkg::KIND_DIGIT: begin
            base = vda_pkg::CH_DIGIT_0;
            span = vda_pkg::SPAN_DIGIT;
         end
         default: ;
      endcase
      if (pop_item.offset >= pop_item.shift) begin
         diff = {1'b0, pop_item.offset} - {1'b0, pop_item.shift};
      end else begin
         diff = {1'b0, pop_item.offset} + {1'b0, span} - {1'b0, pop_item.shift};
      end
      if (pop_item.kind == vda_pkg::KIND_OTHER) begin
         plain = pop_item.text;
      end else begin
         plain = base + vda_pkg::TEXT_W'(diff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= plain;
         rsp_last_ff <= pop_item.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `VDA_ASSERT_NEXT(a_pop_shows, clock, reset, pop, rsp_valid_ff)

endmodule

[src/vigenere_decrypt_alnum.sv]
// Vigenere decryption over letters and digits, one byte per request.
// Channels: req_* carries text_byte in tdata and last_in in tlast; rsp_*
// returns plain_byte in tdata and last_out in tlast; csr_* writes the key
// (index 0, 64 bits of key bytes, byte 0 lowest) and its length (index 1).
// A request is taken when tvalid and tready are both high; each request
// gives exactly one response, in order.
// The front end classifies the byte and reduces the shift into the queue;
// the back end performs the modular subtraction into the response register.
// Throughput: one request per cycle while rsp_tready is high, set by the
// combinational front end and the back end popping the queue whenever
// the response register frees.
// When rsp_tready is low the response holds, the two-entry queue fills and
// req_tready drops once it is full; no request is lost.
// Reset clears the key to zero, the length to one and the key position to
// zero, and empties the queue and response register. Write the registers
// only while no request is in flight.
// Depends on vda_pkg, vda_front, vda_queue and vda_back.

module vigenere_decrypt_alnum (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [vda_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vda_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [vda_pkg::TEXT_W-1:0]         req_tdata,  // text_byte
   input  logic                               req_tlast,  // last_in
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [vda_pkg::TEXT_W-1:0]         rsp_tdata,  // plain_byte
   output logic                               rsp_tlast   // last_out
);

   logic                   push_valid, push_ready;
   vda_pkg::vda_item_type  push_item;
   logic                   pop_valid, pop_ready;
   vda_pkg::vda_item_type  pop_item;

   vda_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   vda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   vda_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
